// File: hdl/pwm_motif_window_scanner_assert.svh
// Assertion macros for the motif window scanner.
`ifndef PWM_MOTIF_WINDOW_SCANNER_ASSERT_SVH
`define PWM_MOTIF_WINDOW_SCANNER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PMWS_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`define PMWS_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");
`define PMWS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define PMWS_ASSERT_NEVER(label, clk, rst_n, expr)
`define PMWS_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define PMWS_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

// File: hdl/pmws_pkg.sv
// Shared types and constants for the motif window scanner.
`default_nettype none
package pmws_pkg;
    localparam int MAX_MOTIF      = 32;
    localparam int POS_W          = $clog2(MAX_MOTIF);
    localparam int LEN_W          = POS_W + 1;
    localparam int COST_W         = 16;
    localparam int SCORE_W        = 20;
    localparam int ACC_W          = SCORE_W + 2;
    localparam int SEQ_W          = 32;
    localparam int IN_DATA_W      = 32;
    localparam int OUT_DATA_W     = 104;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 20;

    localparam logic [COST_W-1:0]  UNK_COST  = 16'd1420;
    localparam logic [2:0]         UNK_CODE  = 3'd4;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 20'hFFFFF;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_BASE = 2'd1,
        REQ_NEW  = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MOTIF_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_OFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_LIMIT = 3'd4;

    typedef struct packed {
        logic             load;
        logic             clear;
        logic             shift;
        logic             issue;
        logic             issue_minus;
        logic [POS_W-1:0] issue_pos;
        logic             issue_last;
        logic             out_minus;
    } cmd_t;

    typedef struct packed {
        logic             scan_ok;
        logic             hit_p;
        logic             hit_m;
        logic [POS_W-1:0] len_m1;
    } stat_t;

    function automatic logic [2:0] base_code(input logic [7:0] c);
        logic [2:0] r;
        begin
            case (c)
                8'h41, 8'h61:               r = 3'd0;
                8'h43, 8'h63:               r = 3'd1;
                8'h47, 8'h67:               r = 3'd2;
                8'h54, 8'h74, 8'h55, 8'h75: r = 3'd3;
                default:                    r = UNK_CODE;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// File: hdl/pmws_ctrl.sv
// Sequencer for the motif window scanner: accepts beats, steps scoring, emits hits.
`default_nettype none
module pmws_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [1:0]    in_kind,
    output logic               in_ready,
    output logic               out_valid,
    output logic               out_last,
    input  wire logic          out_ready,
    input  wire pmws_pkg::stat_t stat,
    output pmws_pkg::cmd_t     cmd
);
    import pmws_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CHECK = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_DRAIN = 7'b0001000,
        ST_SEL   = 7'b0010000,
        ST_OUT_P = 7'b0100000,
        ST_OUT_M = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             minus_reg, minus_next;

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        minus_next      = minus_reg;
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        out_last        = 1'b0;
        cmd             = '0;
        cmd.issue_pos   = pos_reg;
        cmd.issue_minus = minus_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (req_t'(in_kind))
                        REQ_LOAD: cmd.load = 1'b1;
                        REQ_NEW:  cmd.clear = 1'b1;
                        REQ_BASE:
                        begin
                            cmd.shift  = 1'b1;
                            state_next = ST_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK:
            begin
                pos_next   = '0;
                minus_next = 1'b0;
                state_next = stat.scan_ok ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.issue      = 1'b1;
                cmd.issue_last = (pos_reg == stat.len_m1);
                if (cmd.issue_last)
                begin
                    pos_next = '0;
                    if (minus_reg)
                        state_next = ST_DRAIN;
                    else
                        minus_next = 1'b1;
                end
                else
                    pos_next = pos_reg + 1'b1;
            end
            ST_DRAIN: state_next = ST_SEL;
            ST_SEL:
            begin
                if (stat.hit_p)
                    state_next = ST_OUT_P;
                else if (stat.hit_m)
                    state_next = ST_OUT_M;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT_P:
            begin
                out_valid = 1'b1;
                out_last  = !stat.hit_m;
                if (out_ready)
                    state_next = stat.hit_m ? ST_OUT_M : ST_IDLE;
            end
            ST_OUT_M:
            begin
                out_valid     = 1'b1;
                out_last      = 1'b1;
                cmd.out_minus = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            minus_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            minus_reg <= minus_next;
        end
    end
endmodule
`default_nettype wire

// File: hdl/pmws_dpath.sv
// Datapath: config registers, base window, cost table and score accumulators.
`default_nettype none
module pmws_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [pmws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pmws_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [pmws_pkg::IN_DATA_W-1:0]  in_data,
    input  wire pmws_pkg::cmd_t                cmd,
    output pmws_pkg::stat_t                    stat,
    output logic [pmws_pkg::OUT_DATA_W-1:0]    out_data
);
    import pmws_pkg::*;

    logic [LEN_W-1:0]   len_reg, off6, cl_reg;
    logic [POS_W-1:0]   off_reg;
    logic [SCORE_W-1:0] flim_reg, clim_reg;
    logic [2:0]         win_reg [MAX_MOTIF];
    logic [SEQ_W-1:0]   bs_reg;
    logic [COST_W-1:0]  cost_mem [MAX_MOTIF*4];
    logic [COST_W-1:0]  rdata_reg;
    logic               rd_vld_reg, rd_core_reg, rd_unk_reg, rd_last_reg, rd_minus_reg;
    logic [ACC_W-1:0]   full_acc_reg, core_acc_reg;
    logic               hit_p_reg, hit_m_reg;
    logic [SCORE_W-1:0] full_p_reg, core_p_reg, full_m_reg, core_m_reg;

    logic [POS_W-1:0]   entry_pos, win_idx, len_m1;
    logic [1:0]         entry_base, rd_code;
    logic [COST_W-1:0]  entry_cost, cost;
    logic [7:0]         base_char;
    logic [2:0]         b;
    logic [LEN_W:0]     span_end, pos7;
    logic               geo_ok, in_core;
    logic [ACC_W-1:0]   full_sum, core_sum;
    logic [SCORE_W-1:0] full_sat, core_sat;
    logic               hit;
    logic [SEQ_W-1:0]   start_pos;

    assign entry_pos  = in_data[4:0];
    assign entry_base = in_data[6:5];
    assign entry_cost = in_data[22:7];
    assign base_char  = in_data[30:23];

    assign off6     = {1'b0, off_reg};
    assign span_end = {1'b0, off6} + {1'b0, cl_reg};
    assign len_m1   = POS_W'(len_reg - 1'b1);
    assign geo_ok   = (len_reg != '0) && (len_reg <= LEN_W'(MAX_MOTIF)) && (cl_reg != '0)
                      && (span_end <= {1'b0, len_reg});

    assign stat.scan_ok = geo_ok && (bs_reg >= SEQ_W'(len_reg));
    assign stat.hit_p   = hit_p_reg;
    assign stat.hit_m   = hit_m_reg;
    assign stat.len_m1  = len_m1;

    assign win_idx = cmd.issue_minus ? cmd.issue_pos : POS_W'(len_m1 - cmd.issue_pos);
    assign b       = win_reg[win_idx];
    assign rd_code = cmd.issue_minus ? ~b[1:0] : b[1:0];
    assign pos7    = {2'b0, cmd.issue_pos};
    assign in_core = (pos7 >= {1'b0, off6}) && (pos7 < span_end);

    assign cost     = rd_unk_reg ? UNK_COST : rdata_reg;
    assign full_sum = full_acc_reg + ACC_W'(cost);
    assign core_sum = core_acc_reg + (rd_core_reg ? ACC_W'(cost) : '0);
    assign full_sat = (full_sum > ACC_W'(SCORE_MAX)) ? SCORE_MAX : full_sum[SCORE_W-1:0];
    assign core_sat = (core_sum > ACC_W'(SCORE_MAX)) ? SCORE_MAX : core_sum[SCORE_W-1:0];
    assign hit      = (core_sat <= clim_reg) && (full_sat <= flim_reg);

    assign start_pos = bs_reg - SEQ_W'(len_reg) + 1'b1;
    assign out_data  = cmd.out_minus ? {core_m_reg, full_m_reg, bs_reg, start_pos}
                                     : {core_p_reg, full_p_reg, bs_reg, start_pos};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LEN_W'(8);
            off_reg  <= '0;
            cl_reg   <= '0;
            flim_reg <= '0;
            clim_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MOTIF_LEN:  len_reg  <= cfg_wdata[LEN_W-1:0];
                CFG_CORE_OFF:   off_reg  <= cfg_wdata[POS_W-1:0];
                CFG_CORE_LEN:   cl_reg   <= cfg_wdata[LEN_W-1:0];
                CFG_FULL_LIMIT: flim_reg <= cfg_wdata[SCORE_W-1:0];
                CFG_CORE_LIMIT: clim_reg <= cfg_wdata[SCORE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_MOTIF; k++)
                win_reg[k] <= UNK_CODE;
            bs_reg <= '0;
        end
        else if (cmd.clear)
        begin
            for (int k = 0; k < MAX_MOTIF; k++)
                win_reg[k] <= UNK_CODE;
            bs_reg <= '0;
        end
        else if (cmd.shift)
        begin
            win_reg[0] <= base_code(base_char);
            for (int k = 1; k < MAX_MOTIF; k++)
                win_reg[k] <= win_reg[k-1];
            if (!(&bs_reg))
                bs_reg <= bs_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            cost_mem[{entry_pos, entry_base}] <= entry_cost;
        rdata_reg <= cost_mem[{cmd.issue_pos, rd_code}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            rd_core_reg  <= 1'b0;
            rd_unk_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
            rd_minus_reg <= 1'b0;
            full_acc_reg <= '0;
            core_acc_reg <= '0;
            hit_p_reg    <= 1'b0;
            hit_m_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= cmd.issue;
            rd_core_reg  <= in_core;
            rd_unk_reg   <= b[2];
            rd_last_reg  <= cmd.issue_last;
            rd_minus_reg <= cmd.issue_minus;
            if (rd_vld_reg)
            begin
                if (rd_last_reg)
                begin
                    full_acc_reg <= '0;
                    core_acc_reg <= '0;
                    if (rd_minus_reg)
                        hit_m_reg <= hit;
                    else
                        hit_p_reg <= hit;
                end
                else
                begin
                    full_acc_reg <= full_sum;
                    core_acc_reg <= core_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg && rd_last_reg)
        begin
            if (rd_minus_reg)
            begin
                full_m_reg <= full_sat;
                core_m_reg <= core_sat;
            end
            else
            begin
                full_p_reg <= full_sat;
                core_p_reg <= core_sat;
            end
        end
    end
endmodule
`default_nettype wire

// File: hdl/pwm_motif_window_scanner.sv
// Position weight matrix motif scanner: top level.
// Input stream s_axis: tuser is the request kind (load cost entry, base,
// new sequence). Load and new-sequence beats leave the block idle.
// A base beat shifts the window, then, if the window is full and the core
// geometry is valid, both strands are scored by walking the cost table one
// position per cycle through its single read port, plus strand first; the
// hit beats follow once the last cost read has been accumulated.
// Output stream m_axis: zero, one or two hit beats per base, plus strand
// first; tlast marks the final hit of that base.
// One item is in flight at a time: s_axis_tready is high only while idle,
// so a stalled m_axis_tready holds the hit beat and blocks new input.
// Reset clears the window to unknown bases, the position counter to zero
// and the config registers to their defaults; the cost table is not
// cleared and must be loaded before scanning.
// Config port: cfg_we writes cfg_wdata to register cfg_index; the user must
// write only while the block is idle, which the block does not enforce.
`default_nettype none
`include "pwm_motif_window_scanner_assert.svh"
module pwm_motif_window_scanner (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // entry_position, entry_base, entry_cost, base_char, zero pad
    input  wire logic [pmws_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic [1:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // start_pos, end_pos, full window score, core span score
    output logic [pmws_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // hit_strand
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [pmws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pmws_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pmws_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pmws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_kind   (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_last  (m_axis_tlast),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pmws_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_axis_tdata)
    );

    assign m_axis_tuser = cmd.out_minus;

    `PMWS_ASSERT_NEVER(a_no_overlap, clk, rst_n, s_axis_tready && m_axis_tvalid)
    `PMWS_ASSERT_IMPLY(a_minus_last, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    `PMWS_ASSERT_IMPLY(a_minus_has_hit, clk, rst_n, m_axis_tvalid && m_axis_tuser, stat.hit_m)
    `PMWS_ASSERT_NEXT(a_base_busy, clk, rst_n,
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_BASE), !s_axis_tready)
endmodule
`default_nettype wire
